@@ design/rmq_pkg.sv @@
// Shared widths, constants and pipeline payload types for the rotation matrix to quaternion core.
package rmq_pkg;

  localparam int DATA_W    = 16;
  localparam int FRAC_BITS = 14;
  localparam longint ONE   = longint'(1) << FRAC_BITS;

  // Square root argument, result and division widths
  localparam int A_W   = (FRAC_BITS > 17 ? FRAC_BITS : 17) + 1;
  localparam int S_W   = A_W + 2;
  localparam int SQ_W  = ((A_W + FRAC_BITS + 1) / 2) * 2;
  localparam int R_W   = SQ_W / 2;
  localparam int MAG_W = 17;
  localparam int N_W   = ((MAG_W + FRAC_BITS > R_W) ? MAG_W + FRAC_BITS : R_W) + 1;
  localparam int D_W   = R_W + 1;

  // Saturation limits on magnitude
  localparam longint SAT_HI = (ONE > 32767) ? 32767 : ONE;
  localparam longint SAT_LO = (ONE > 32768) ? 32768 : ONE;

  // Position of the component that comes from the square root
  localparam logic [1:0] POS_X = 2'd0;
  localparam logic [1:0] POS_Y = 2'd1;
  localparam logic [1:0] POS_Z = 2'd2;
  localparam logic [1:0] POS_W = 2'd3;

  typedef struct packed {
    logic [1:0]                  pos;
    logic                        bad;
    logic [2:0]                  sgn;
    logic [2:0][MAG_W-1:0]       mag;
  } side_t;

  typedef struct packed {
    logic [SQ_W-1:0]  rad;
    logic [R_W+1:0]   rem;
    logic [R_W-1:0]   root;
    side_t            side;
  } sqrt_t;

  typedef struct packed {
    logic [2:0][N_W-1:0] num;
    logic [2:0][D_W-1:0] rem;
    logic [2:0][N_W-1:0] quo;
    logic [D_W-1:0]      den;
    logic [R_W-1:0]      root;
    side_t               side;
  } div_t;

endpackage

@@ design/rmq_front.sv @@
// Front stage: trace test, branch choice, square root argument and signed dividends.
module rmq_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              vin,
  input  logic signed [rmq_pkg::DATA_W-1:0] r00,
  input  logic signed [rmq_pkg::DATA_W-1:0] r01,
  input  logic signed [rmq_pkg::DATA_W-1:0] r02,
  input  logic signed [rmq_pkg::DATA_W-1:0] r10,
  input  logic signed [rmq_pkg::DATA_W-1:0] r11,
  input  logic signed [rmq_pkg::DATA_W-1:0] r12,
  input  logic signed [rmq_pkg::DATA_W-1:0] r20,
  input  logic signed [rmq_pkg::DATA_W-1:0] r21,
  input  logic signed [rmq_pkg::DATA_W-1:0] r22,
  output logic                              vout,
  output rmq_pkg::sqrt_t                    dout
);

  localparam int SW = rmq_pkg::S_W;

  logic signed [SW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [SW-1:0] trace, a_val, one_s;
  logic signed [SW-1:0] dv [3];
  logic                 tpos, bad;
  logic [1:0]           pos;
  rmq_pkg::sqrt_t       dout_next;

  always_comb begin
    m00   = SW'(r00);
    m01   = SW'(r01);
    m02   = SW'(r02);
    m10   = SW'(r10);
    m11   = SW'(r11);
    m12   = SW'(r12);
    m20   = SW'(r20);
    m21   = SW'(r21);
    m22   = SW'(r22);
    one_s = SW'(rmq_pkg::ONE);
    trace = m00 + m11 + m22;
    tpos  = (trace > 0);
    if (tpos) begin
      pos   = rmq_pkg::POS_W;
      a_val = trace + one_s;
      dv[0] = m21 - m12;
      dv[1] = m02 - m20;
      dv[2] = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      pos   = rmq_pkg::POS_X;
      a_val = one_s + m00 - m11 - m22;
      dv[0] = m01 + m10;
      dv[1] = m02 + m20;
      dv[2] = m21 - m12;
    end else if (m11 > m22) begin
      pos   = rmq_pkg::POS_Y;
      a_val = one_s + m11 - m00 - m22;
      dv[0] = m01 + m10;
      dv[1] = m12 + m21;
      dv[2] = m02 - m20;
    end else begin
      pos   = rmq_pkg::POS_Z;
      a_val = one_s + m22 - m00 - m11;
      dv[0] = m02 + m20;
      dv[1] = m12 + m21;
      dv[2] = m10 - m01;
    end
    bad = !tpos && (a_val <= 0);

    dout_next.rad  = bad ? '0 :
                     rmq_pkg::SQ_W'({a_val[rmq_pkg::A_W-1:0], {rmq_pkg::FRAC_BITS{1'b0}}});
    dout_next.rem  = '0;
    dout_next.root = '0;
    dout_next.side.pos = pos;
    dout_next.side.bad = bad;
    for (int i = 0; i < 3; i++) begin
      dout_next.side.sgn[i] = dv[i][SW-1];
      dout_next.side.mag[i] = dv[i][SW-1] ? rmq_pkg::MAG_W'(-dv[i]) : rmq_pkg::MAG_W'(dv[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

@@ design/rmq_sqrt_cell.sv @@
// Square root cell: one restoring root bit per cell.
module rmq_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vin,
  input  rmq_pkg::sqrt_t din,
  output logic           vout,
  output rmq_pkg::sqrt_t dout
);

  localparam int RW = rmq_pkg::R_W;

  logic [RW+1:0]  rem_sh, trial;
  logic           ge;
  rmq_pkg::sqrt_t dout_next;

  always_comb begin
    rem_sh = {din.rem[RW-1:0], din.rad[rmq_pkg::SQ_W-1 -: 2]};
    trial  = {din.root, 2'b01};
    ge     = (rem_sh >= trial);
    dout_next      = din;
    dout_next.rad  = din.rad << 2;
    dout_next.rem  = ge ? rem_sh - trial : rem_sh;
    dout_next.root = {din.root[RW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

@@ design/rmq_div_cell.sv @@
// Division cell: one restoring quotient bit per cell in each of three lanes.
module rmq_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  rmq_pkg::div_t din,
  output logic          vout,
  output rmq_pkg::div_t dout
);

  localparam int DW = rmq_pkg::D_W;
  localparam int NW = rmq_pkg::N_W;

  logic [DW:0]   rs [3];
  logic [2:0]    ge;
  rmq_pkg::div_t dout_next;

  always_comb begin
    dout_next = din;
    for (int i = 0; i < 3; i++) begin
      rs[i] = {din.rem[i], din.num[i][NW-1]};
      ge[i] = (rs[i] >= {1'b0, din.den});
      dout_next.rem[i] = ge[i] ? DW'(rs[i] - {1'b0, din.den}) : DW'(rs[i]);
      dout_next.quo[i] = {din.quo[i][NW-2:0], ge[i]};
      dout_next.num[i] = din.num[i] << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

@@ design/rmq_back.sv @@
// Back stage: place components, apply sign and saturation or zero a bad input, hold the result register.
module rmq_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               vin,
  input  rmq_pkg::div_t                      din,
  output logic                               vout,
  output logic signed [rmq_pkg::DATA_W-1:0]  q_x,
  output logic signed [rmq_pkg::DATA_W-1:0]  q_y,
  output logic signed [rmq_pkg::DATA_W-1:0]  q_z,
  output logic signed [rmq_pkg::DATA_W-1:0]  q_w,
  output logic                               invalid
);

  localparam int NW = rmq_pkg::N_W;
  localparam int DW = rmq_pkg::DATA_W;

  logic [rmq_pkg::R_W:0]  root_rnd;
  logic [NW-1:0]          mag [4];
  logic                   neg [4];
  logic [1:0]             idx [4];
  logic signed [DW-1:0]   res [4];

  always_comb begin
    root_rnd = ({1'b0, din.root} + 1'b1) >> 1;
    for (int k = 0; k < 4; k++) begin
      idx[k] = (2'(k) > din.side.pos) ? 2'(k - 1) : 2'(k);
      if (2'(k) == din.side.pos) begin
        mag[k] = NW'(root_rnd);
        neg[k] = 1'b0;
      end else begin
        mag[k] = din.quo[idx[k]];
        neg[k] = din.side.sgn[idx[k]];
      end
      if (din.side.bad) begin
        res[k] = '0;
      end else if (!neg[k]) begin
        res[k] = (mag[k] > NW'(rmq_pkg::SAT_HI)) ? DW'(rmq_pkg::SAT_HI) : DW'(mag[k]);
      end else begin
        res[k] = (mag[k] > NW'(rmq_pkg::SAT_LO)) ? -DW'(rmq_pkg::SAT_LO) : -DW'(mag[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_x     <= res[0];
      q_y     <= res[1];
      q_z     <= res[2];
      q_w     <= res[3];
      invalid <= din.side.bad;
    end
  end

endmodule

@@ design/rotation_matrix_to_quaternion_core.sv @@
// Top level: rotation matrix to quaternion pipeline of square root and divider cells.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid, in_stall, r00 .. r22       | into core
//  output  | out_valid, out_stall, q_x .. q_w,    | out of core
//          | invalid                              |
//
// One transaction per cycle while the output is not stalled; the pipeline holds
// one front stage, one square root cell per root bit, one divider cell per quotient bit,
// and the output register. Reset clears only the valid bits of the chain.
// A stalled output holding a valid result freezes the whole chain; in_stall follows it, and a waiting result
// never blocks intake while the output register is empty.
module rotation_matrix_to_quaternion_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [rmq_pkg::DATA_W-1:0] r00,
  input  logic signed [rmq_pkg::DATA_W-1:0] r01,
  input  logic signed [rmq_pkg::DATA_W-1:0] r02,
  input  logic signed [rmq_pkg::DATA_W-1:0] r10,
  input  logic signed [rmq_pkg::DATA_W-1:0] r11,
  input  logic signed [rmq_pkg::DATA_W-1:0] r12,
  input  logic signed [rmq_pkg::DATA_W-1:0] r20,
  input  logic signed [rmq_pkg::DATA_W-1:0] r21,
  input  logic signed [rmq_pkg::DATA_W-1:0] r22,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rmq_pkg::DATA_W-1:0] q_x,
  output logic signed [rmq_pkg::DATA_W-1:0] q_y,
  output logic signed [rmq_pkg::DATA_W-1:0] q_z,
  output logic signed [rmq_pkg::DATA_W-1:0] q_w,
  output logic                              invalid
);

  localparam int RW = rmq_pkg::R_W;
  localparam int NW = rmq_pkg::N_W;

  logic           en;
  logic           sq_v [RW+1];
  rmq_pkg::sqrt_t sq_d [RW+1];
  logic           dv_v [NW+1];
  rmq_pkg::div_t  dv_d [NW+1];

  // advance everything unless a finished result is held
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  rmq_front u_front (
    .clk (clk), .rst (rst), .en (en), .vin (in_valid),
    .r00 (r00), .r01 (r01), .r02 (r02),
    .r10 (r10), .r11 (r11), .r12 (r12),
    .r20 (r20), .r21 (r21), .r22 (r22),
    .vout (sq_v[0]), .dout (sq_d[0])
  );

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk (clk), .rst (rst), .en (en),
      .vin (sq_v[i]), .din (sq_d[i]),
      .vout (sq_v[i+1]), .dout (sq_d[i+1])
    );
  end

  // form rounded numerators mag * ONE + root and divisor 2 * root
  always_comb begin
    dv_v[0]      = sq_v[RW];
    dv_d[0].den  = {sq_d[RW].root, 1'b0};
    dv_d[0].root = sq_d[RW].root;
    dv_d[0].side = sq_d[RW].side;
    for (int i = 0; i < 3; i++) begin
      dv_d[0].num[i] = (NW'(sq_d[RW].side.mag[i]) << rmq_pkg::FRAC_BITS) + NW'(sq_d[RW].root);
      dv_d[0].rem[i] = '0;
      dv_d[0].quo[i] = '0;
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_div
    rmq_div_cell u_cell (
      .clk (clk), .rst (rst), .en (en),
      .vin (dv_v[i]), .din (dv_d[i]),
      .vout (dv_v[i+1]), .dout (dv_d[i+1])
    );
  end

  rmq_back u_back (
    .clk (clk), .rst (rst), .en (en),
    .vin (dv_v[NW]), .din (dv_d[NW]),
    .vout (out_valid),
    .q_x (q_x), .q_y (q_y), .q_z (q_z), .q_w (q_w),
    .invalid (invalid)
  );

endmodule
